FILE: sv/bfha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfha_pkg
// shared types and codes for the best-fit heap allocator
// ----------------------------------------------------------------------------
package bfha_pkg;

    localparam int unsigned FIELD_BITS = 20;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_FREED     = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t               opcode;
        logic [FIELD_BITS-1:0] request_size;
        logic [FIELD_BITS-1:0] payload_offset;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [FIELD_BITS-1:0] result_offset;
    } rsp_t;

endpackage
`default_nettype wire

FILE: sv/best_fit_heap_allocator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_top
// best-fit heap allocator with split and coalescing over a block table
// ----------------------------------------------------------------------------
// One request at a time. A request scans the block table through the single
// read port of the table memory, one entry at a time (read, then compare),
// then shifts entries one at a time (read, then write) on a split or merge.
// Writing heap_size re-initializes the table: only entry 0 and the count are
// set, since unused entries are never read. After reset, entry 0 is first
// cleared to a free block of zero length, and the block stalls meanwhile.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator_top #(
    parameter int unsigned MAX_BLOCKS   = 64,
    parameter int unsigned HEADER_BYTES = 12,
    parameter int unsigned OFFSET_BITS  = 20
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire bfha_pkg::req_t in_data,
    output logic               out_valid,
    input  wire logic          out_stall,
    output bfha_pkg::rsp_t     out_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [bfha_pkg::FIELD_BITS-1:0] cfg_data
);

    localparam int unsigned W  = bfha_pkg::FIELD_BITS;
    localparam int unsigned IB = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned CB = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned OB = OFFSET_BITS;
    localparam logic [W+1:0] HDR = (W+2)'(HEADER_BYTES);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RD    = 11'b00000000010,
        S_CHK   = 11'b00000000100,
        S_DEC   = 11'b00000001000,
        S_MRD   = 11'b00000010000,
        S_MWR   = 11'b00000100000,
        S_NRD   = 11'b00001000000,
        S_NCHK  = 11'b00010000000,
        S_PRD   = 11'b00100000000,
        S_PCHK  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    // move kinds for the shift engine
    typedef enum logic [1:0] {
        MV_INS = 2'd0,
        MV_DEL = 2'd1,
        MV_END = 2'd2
    } mv_t;

    state_t state_reg, state_next;
    logic          init_reg;
    logic [CB-1:0] count_reg, count_next;
    logic [CB-1:0] idx_reg, idx_next;
    logic [IB-1:0] best_reg, best_next;
    logic          found_reg, found_next;
    logic [W-1:0]  blen_reg, blen_next;
    logic [W-1:0]  bstart_reg, bstart_next;
    logic          op_reg;
    logic [W-1:0]  size_reg, hdr_reg;
    logic          hdr_ok_reg;
    mv_t           mv_reg, mv_next;
    logic [CB-1:0] mv_lo_reg, mv_lo_next;
    // merge state for free
    logic [W-1:0]  cur_len_reg, cur_len_next;
    logic [W-1:0]  cur_start_reg, cur_start_next;
    bfha_pkg::rsp_t rsp_reg, rsp_next;

    logic          wr_en;
    logic [IB-1:0] wr_addr, rd_addr;
    logic [W-1:0]  wr_start, wr_len, rd_start, rd_len;
    logic          wr_used, rd_used;

    bfha_table #(.DEPTH(MAX_BLOCKS), .IDX_BITS(IB), .W(W)) u_table (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_start(wr_start),
        .wr_len(wr_len), .wr_used(wr_used), .rd_addr(rd_addr),
        .rd_start(rd_start), .rd_len(rd_len), .rd_used(rd_used)
    );

    // init on config: entry 0 written in the same cycle
    logic          cfg_fire;
    logic [W-1:0]  init_len;
    assign cfg_ready = (state_reg == S_IDLE) && !out_valid && !init_reg;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign init_len  = (cfg_data >= W'(HEADER_BYTES)) ? cfg_data - W'(HEADER_BYTES) : '0;

    assign in_stall  = (state_reg != S_IDLE) || out_valid || cfg_valid || init_reg;
    assign out_data  = rsp_reg;

    logic [W+1:0] sum_q;
    logic         rd_free;
    assign rd_free = !rd_used && (rd_len != '0);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        blen_next      = blen_reg;
        bstart_next    = bstart_reg;
        mv_next        = mv_reg;
        mv_lo_next     = mv_lo_reg;
        cur_len_next   = cur_len_reg;
        cur_start_next = cur_start_reg;
        rsp_next       = rsp_reg;
        wr_en    = 1'b0;
        wr_addr  = idx_reg[IB-1:0];
        wr_start = '0;
        wr_len   = '0;
        wr_used  = 1'b0;
        rd_addr  = idx_reg[IB-1:0];
        sum_q    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (init_reg)
                begin
                    // empty heap after reset: entry 0 free with zero length
                    wr_en   = 1'b1;
                    wr_addr = '0;
                end
                else if (cfg_fire)
                begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_len  = init_len;
                    count_next = CB'(1);
                end
                else if (in_valid && !in_stall)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                // data for entry idx is on the read port
                if (op_reg == bfha_pkg::OP_ALLOC)
                begin
                    if (rd_free && rd_len >= size_reg && (!found_reg || rd_len < blen_reg))
                    begin
                        found_next  = 1'b1;
                        best_next   = idx_reg[IB-1:0];
                        blen_next   = rd_len;
                        bstart_next = rd_start;
                    end
                    if (idx_reg + CB'(1) >= count_reg)
                        state_next = S_DEC;
                    else
                    begin
                        idx_next   = idx_reg + CB'(1);
                        state_next = S_RD;
                    end
                end
                else
                begin
                    if (hdr_ok_reg && rd_start == hdr_reg)
                    begin
                        best_next      = idx_reg[IB-1:0];
                        cur_len_next   = rd_len;
                        cur_start_next = rd_start;
                        idx_next       = idx_reg + CB'(1);
                        state_next     = S_NRD;
                    end
                    else if (!hdr_ok_reg || idx_reg + CB'(1) >= count_reg)
                    begin
                        rsp_next   = '{bfha_pkg::ST_IGNORED, '0};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CB'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_DEC:
            begin
                if (!found_reg)
                begin
                    rsp_next   = '{bfha_pkg::ST_NO_FIT, '0};
                    state_next = S_OUT;
                end
                else
                begin
                    rsp_next = '{bfha_pkg::ST_ALLOCATED,
                                 W'(OB'(bstart_reg + W'(HEADER_BYTES)))};
                    sum_q = {2'b00, size_reg} + HDR;
                    if ({2'b00, blen_reg} > sum_q && count_reg < CB'(MAX_BLOCKS))
                    begin
                        // chosen block shrinks to the request size, tail goes in at best+1
                        wr_en    = 1'b1;
                        wr_addr  = best_reg;
                        wr_start = bstart_reg;
                        wr_len   = size_reg;
                        wr_used  = 1'b1;
                        mv_next    = MV_INS;
                        mv_lo_next = CB'(best_reg) + CB'(1);
                        idx_next   = count_reg;
                        state_next = S_MRD;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = best_reg;
                        wr_start = bstart_reg;
                        wr_len   = blen_reg;
                        wr_used  = 1'b1;
                        state_next = S_OUT;
                    end
                end
            end
            S_MRD:
            begin
                // shift engine: read the source entry, or finish when the move is done
                if (mv_reg == MV_INS)
                begin
                    if (idx_reg == mv_lo_reg)
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = idx_reg[IB-1:0];
                        wr_start = W'(OB'(bstart_reg + W'(HEADER_BYTES) + size_reg));
                        wr_len   = blen_reg - size_reg - W'(HEADER_BYTES);
                        count_next = count_reg + CB'(1);
                        state_next = S_OUT;
                    end
                    else
                    begin
                        rd_addr    = IB'(idx_reg - CB'(1));
                        state_next = S_MWR;
                    end
                end
                else
                begin
                    if (idx_reg + CB'(1) >= count_reg)
                    begin
                        count_next = count_reg - CB'(1);
                        state_next = mv_reg == MV_END ? S_OUT : S_PRD;
                        idx_next   = CB'(best_reg);
                    end
                    else
                    begin
                        rd_addr    = IB'(idx_reg + CB'(1));
                        state_next = S_MWR;
                    end
                end
            end
            S_MWR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[IB-1:0];
                wr_start = rd_start;
                wr_len   = rd_len;
                wr_used  = rd_used;
                idx_next = (mv_reg == MV_INS) ? idx_reg - CB'(1) : idx_reg + CB'(1);
                state_next = S_MRD;
            end
            S_NRD:
            begin
                // write current as free first
                wr_en    = 1'b1;
                wr_addr  = best_reg;
                wr_start = cur_start_reg;
                wr_len   = cur_len_reg;
                if (idx_reg >= count_reg)
                begin
                    state_next = S_PRD;
                end
                else
                    state_next = S_NCHK;
            end
            S_NCHK:
            begin
                if (rd_free)
                begin
                    cur_len_next = cur_len_reg + rd_len + W'(HEADER_BYTES);
                    wr_en    = 1'b1;
                    wr_addr  = best_reg;
                    wr_start = cur_start_reg;
                    wr_len   = cur_len_reg + rd_len + W'(HEADER_BYTES);
                    mv_next    = MV_DEL;
                    state_next = S_MRD;
                end
                else
                    state_next = S_PRD;
            end
            S_PRD:
            begin
                if (best_reg == '0)
                begin
                    rsp_next   = '{bfha_pkg::ST_FREED, '0};
                    state_next = S_OUT;
                end
                else
                begin
                    rd_addr    = best_reg - IB'(1);
                    state_next = S_PCHK;
                end
            end
            S_PCHK:
            begin
                rsp_next = '{bfha_pkg::ST_FREED, '0};
                if (rd_free)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = best_reg - IB'(1);
                    wr_start = rd_start;
                    wr_len   = rd_len + cur_len_reg + W'(HEADER_BYTES);
                    mv_next    = MV_END;
                    idx_next   = CB'(best_reg);
                    state_next = S_MRD;
                end
                else
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // the next-neighbor read must present entry idx during S_NRD
    logic ovalid_reg;
    assign out_valid = ovalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            init_reg   <= 1'b1;
            count_reg  <= CB'(1);
            ovalid_reg <= 1'b0;
            idx_reg    <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= 1'b0;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            if (state_reg == S_OUT)
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        blen_reg      <= blen_next;
        bstart_reg    <= bstart_next;
        mv_reg        <= mv_next;
        mv_lo_reg     <= mv_lo_next;
        cur_len_reg   <= cur_len_next;
        cur_start_reg <= cur_start_next;
        rsp_reg       <= rsp_next;
        if (state_reg == S_IDLE && in_valid && !in_stall)
        begin
            op_reg     <= in_data.opcode;
            size_reg   <= in_data.request_size;
            hdr_ok_reg <= in_data.payload_offset >= W'(HEADER_BYTES);
            hdr_reg    <= in_data.payload_offset - W'(HEADER_BYTES);
        end
    end

endmodule
`default_nettype wire

FILE: sv/bfha_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfha_table
// block table memory: start, length and in-use per entry, a write port and a read port each cycle
// ----------------------------------------------------------------------------
module bfha_table #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned IDX_BITS = 6,
    parameter int unsigned W = 20
) (
    input  wire logic                clk,
    input  wire logic                wr_en,
    input  wire logic [IDX_BITS-1:0] wr_addr,
    input  wire logic [W-1:0]        wr_start,
    input  wire logic [W-1:0]        wr_len,
    input  wire logic                wr_used,
    input  wire logic [IDX_BITS-1:0] rd_addr,
    output logic      [W-1:0]        rd_start,
    output logic      [W-1:0]        rd_len,
    output logic                     rd_used
);

    logic [2*W:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_start, wr_len, wr_used};
        end
        {rd_start, rd_len, rd_used} <= mem[rd_addr];
    end

endmodule
`default_nettype wire
